// ===== design/hvt_pkg.sv =====
// ----------------------------------------------------------------------------
// hvt_pkg
// Shared types, character codes and entity tables of the visible-text filter.
// ----------------------------------------------------------------------------
package hvt_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam logic [15:0] LIMIT_RESET = 16'd640;
  localparam int QUEUE_DEPTH = 4;

  localparam int NUM_ENT     = 6;
  localparam int ENT_MAX_LEN = 5;
  // replay sequence: '&', up to ENT_MAX_LEN - 1 held bytes, the breaking byte
  localparam int SEQ_DEPTH   = ENT_MAX_LEN + 1;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CASE_GAP = 8'h20;

  // entity names without the leading '&'
  localparam logic [7:0] ENT_NAME [NUM_ENT][ENT_MAX_LEN] = '{
    '{8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},   // amp;
    '{8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},   // lt;
    '{8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},   // gt;
    '{8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},   // quot;
    '{8'h23, 8'h33, 8'h39, 8'h3B, 8'h00},   // #39;
    '{8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B}    // apos;
  };
  localparam logic [2:0] ENT_LEN [NUM_ENT] = '{3'd4, 3'd3, 3'd3, 3'd5, 3'd4, 3'd5};
  localparam logic [7:0] ENT_VAL [NUM_ENT] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27, 8'h27};

  typedef struct packed {
    logic [7:0] raw;
    logic [7:0] lc;
    logic       ws;
    logic       lt;
    logic       gt;
    logic       amp;
  } hvt_cls_t;

  typedef struct packed {
    hvt_cls_t cls;
    logic     last;
  } hvt_item_t;

  function automatic hvt_cls_t classify_byte(input logic [7:0] b);
    hvt_cls_t c;
    c.raw = b;
    c.lc  = (b >= CH_UP_A && b <= CH_UP_Z) ? b + CASE_GAP : b;
    c.ws  = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    c.lt  = (b == CH_LT);
    c.gt  = (b == CH_GT);
    c.amp = (b == CH_AMP);
    return c;
  endfunction

endpackage

// ===== design/hvt_front.sv =====
// ----------------------------------------------------------------------------
// hvt_front
// Input side: takes byte beats and tags each with its character class.
// ----------------------------------------------------------------------------
module hvt_front (
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // in_byte
  input  logic                s_tlast,   // last_byte
  input  logic                q_full,
  output logic                push,
  output hvt_pkg::hvt_item_t  push_item
);

  assign s_tready       = !q_full;
  assign push           = s_tvalid && !q_full;
  assign push_item.cls  = hvt_pkg::classify_byte(s_tdata);
  assign push_item.last = s_tlast;

endmodule

// ===== design/hvt_queue.sv =====
// ----------------------------------------------------------------------------
// hvt_queue
// Short queue of classified bytes between the front and the back end.
// ----------------------------------------------------------------------------
module hvt_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  hvt_pkg::hvt_item_t  push_item,
  output logic                full,
  input  logic                pop,
  output logic                valid,
  output hvt_pkg::hvt_item_t  head
);

  localparam int DEPTH = hvt_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  hvt_pkg::hvt_item_t slots [DEPTH];
  logic [AW-1:0]      wr_ptr;
  logic [AW-1:0]      rd_ptr;
  logic [AW:0]        fill;

  assign full  = (fill == (AW+1)'(DEPTH));
  assign valid = (fill != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      fill <= fill + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

// ===== design/hvt_back.sv =====
// ----------------------------------------------------------------------------
// hvt_back
// Back end: markup, entity and whitespace state, replay sequencer, limit
// tracking and the registered output stage.
// ----------------------------------------------------------------------------
module hvt_back #(
  parameter int COUNT_BITS = hvt_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data,
  input  logic                q_valid,
  input  hvt_pkg::hvt_item_t  q_item,
  output logic                q_pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [23:0]         m_tdata,
  output logic                m_tlast
);

  localparam int SW   = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
  localparam int SEQD = hvt_pkg::SEQ_DEPTH;
  localparam int EBD  = hvt_pkg::ENT_MAX_LEN - 1;
  localparam int MHD  = 4;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // registers
  logic [15:0]           limit;
  logic                  in_markup,  in_markup_next;
  logic [MHD-1:0][7:0]   mhead,      mhead_next;
  logic [2:0]            mcnt,       mcnt_next;
  logic [EBD-1:0][7:0]   ebuf,       ebuf_next;
  logic [2:0]            ecnt,       ecnt_next;
  logic                  space_pend, space_pend_next;
  logic [COUNT_BITS-1:0] emitted,    emitted_next;
  logic                  lim_hit,    lim_hit_next;
  hvt_pkg::hvt_cls_t     seq        [SEQD];
  hvt_pkg::hvt_cls_t     seq_next   [SEQD];
  logic [2:0]            seq_len,    seq_len_next;
  logic                  seq_vis,    seq_vis_next;
  logic                  last_pend,  last_pend_next;

  // entity match
  logic [7:0]            tail [hvt_pkg::ENT_MAX_LEN];
  logic [hvt_pkg::NUM_ENT-1:0] pm;
  logic                  ent_hit;
  logic                  ent_full;
  logic [7:0]            ent_val;

  // op execution
  logic                  use_seq, use_flush, use_raw, raw_ent;
  logic                  op_act, op_vis, op_done;
  hvt_pkg::hvt_cls_t     op_cls;
  logic [7:0]            op_byte;
  logic                  out_free;
  logic [SW-1:0]         fill_sum;
  logic [SW-1:0]         count_ext;
  logic                  stop;
  logic                  sep_head;
  logic                  emit;
  logic [7:0]            emit_byte;
  logic                  emit_eot;
  logic [15:0]           emit_len;
  logic [COUNT_BITS-1:0] bumped;
  hvt_pkg::hvt_cls_t     replay_cls [SEQD];

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign count_ext = SW'(emitted);
  assign fill_sum  = count_ext + SW'(space_pend) + SW'(1);
  assign stop      = lim_hit || (fill_sum >= SW'(limit));
  assign bumped    = (emitted == CNT_MAX) ? emitted : emitted + COUNT_BITS'(1);

  assign sep_head =
      (mcnt >= 3'd2 && mhead[0] == hvt_pkg::CH_B && mhead[1] == hvt_pkg::CH_R) ||
      (mcnt >= 3'd2 && mhead[0] == hvt_pkg::CH_SLASH && mhead[1] == hvt_pkg::CH_P) ||
      (mcnt >= 3'd4 && mhead[0] == hvt_pkg::CH_SLASH && mhead[1] == hvt_pkg::CH_D &&
       mhead[2] == hvt_pkg::CH_I && mhead[3] == hvt_pkg::CH_V) ||
      (mcnt >= 3'd3 && mhead[0] == hvt_pkg::CH_SLASH && mhead[1] == hvt_pkg::CH_L &&
       mhead[2] == hvt_pkg::CH_I);

  // held bytes after '&' followed by the incoming byte
  always_comb begin
    for (int i = 0; i < hvt_pkg::ENT_MAX_LEN; i++) begin
      if (i < EBD && 3'(i) != ecnt - 3'd1) begin
        tail[i] = ebuf[i];
      end else begin
        tail[i] = q_item.cls.raw;
      end
    end
    for (int e = 0; e < hvt_pkg::NUM_ENT; e++) begin
      pm[e] = (ecnt <= hvt_pkg::ENT_LEN[e]);
      for (int i = 0; i < hvt_pkg::ENT_MAX_LEN; i++) begin
        if (3'(i) < ecnt && tail[i] != hvt_pkg::ENT_NAME[e][i]) begin
          pm[e] = 1'b0;
        end
      end
    end
    ent_hit  = 1'b0;
    ent_full = 1'b0;
    ent_val  = '0;
    for (int e = 0; e < hvt_pkg::NUM_ENT; e++) begin
      if (!ent_hit && pm[e]) begin
        ent_hit  = 1'b1;
        ent_full = (ecnt == hvt_pkg::ENT_LEN[e]);
        ent_val  = hvt_pkg::ENT_VAL[e];
      end
    end
  end

  // replay: '&' then the held bytes
  always_comb begin
    replay_cls[0] = hvt_pkg::classify_byte(hvt_pkg::CH_AMP);
    for (int j = 1; j <= EBD; j++) begin
      replay_cls[j] = hvt_pkg::classify_byte(ebuf[j-1]);
    end
    for (int j = EBD + 1; j < SEQD; j++) begin
      replay_cls[j] = q_item.cls;
    end
  end

  always_comb begin
    in_markup_next  = in_markup;
    mhead_next      = mhead;
    mcnt_next       = mcnt;
    ebuf_next       = ebuf;
    ecnt_next       = ecnt;
    space_pend_next = space_pend;
    emitted_next    = emitted;
    lim_hit_next    = lim_hit;
    seq_next        = seq;
    seq_len_next    = seq_len;
    seq_vis_next    = seq_vis;
    last_pend_next  = last_pend;
    q_pop           = 1'b0;
    op_done         = 1'b0;
    emit            = 1'b0;
    emit_byte       = '0;
    emit_eot        = 1'b0;
    emit_len        = '0;

    use_seq   = (seq_len != 3'd0);
    use_flush = !use_seq && last_pend;
    use_raw   = !use_seq && !last_pend && q_valid;
    raw_ent   = use_raw && (ecnt != 3'd0);
    op_act    = use_seq || (use_raw && ecnt == 3'd0) || (raw_ent && ent_hit && ent_full);
    op_cls    = use_seq ? seq[0] : q_item.cls;
    op_vis    = use_seq ? seq_vis : raw_ent;
    op_byte   = use_seq ? seq[0].raw : (raw_ent ? ent_val : q_item.cls.raw);

    if (op_act) begin
      if (stop) begin
        lim_hit_next = 1'b1;
        op_done      = 1'b1;
      end else if (op_vis || (!op_cls.lt && !in_markup && !op_cls.amp && !op_cls.ws)) begin
        emit      = 1'b1;
        emit_byte = space_pend ? hvt_pkg::CH_SPACE : op_byte;
        if (out_free) begin
          emitted_next = bumped;
          if (space_pend) begin
            // held space goes out first, the byte follows as the next beat
            space_pend_next = 1'b0;
          end else begin
            op_done = 1'b1;
          end
        end
      end else if (op_cls.lt) begin
        in_markup_next = 1'b1;
        mcnt_next      = '0;
        op_done        = 1'b1;
      end else if (in_markup) begin
        op_done = 1'b1;
        if (op_cls.gt) begin
          if (sep_head && emitted != '0) begin
            space_pend_next = 1'b1;
          end
          in_markup_next = 1'b0;
          mcnt_next      = '0;
        end else if (mcnt < 3'(MHD)) begin
          mhead_next[mcnt[1:0]] = op_cls.lc;
          mcnt_next             = mcnt + 3'd1;
        end
      end else if (op_cls.amp) begin
        ecnt_next = 3'd1;
        op_done   = 1'b1;
      end else begin
        if (emitted != '0) begin
          space_pend_next = 1'b1;
        end
        op_done = 1'b1;
      end
    end

    if (use_seq && op_done) begin
      for (int j = 0; j < SEQD - 1; j++) begin
        seq_next[j] = seq[j+1];
      end
      seq_len_next = seq_len - 3'd1;
      seq_vis_next = 1'b0;
    end

    if (use_raw) begin
      if (ecnt == 3'd0) begin
        q_pop = op_done;
      end else if (ent_hit && ent_full) begin
        q_pop = op_done;
        if (op_done) begin
          ecnt_next = 3'd0;
        end
      end else if (ent_hit && ecnt < 3'(hvt_pkg::ENT_MAX_LEN)) begin
        q_pop = 1'b1;
        ebuf_next[2'(ecnt - 3'd1)] = q_item.cls.raw;
        ecnt_next = ecnt + 3'd1;
      end else begin
        // mismatch: '&', held bytes, then the breaking byte as plain input
        q_pop     = 1'b1;
        ecnt_next = 3'd0;
        for (int j = 0; j < SEQD; j++) begin
          seq_next[j] = (3'(j) == ecnt) ? q_item.cls : replay_cls[j];
        end
        seq_len_next = ecnt + 3'd1;
        seq_vis_next = 1'b1;
      end
      if (q_pop && q_item.last) begin
        last_pend_next = 1'b1;
      end
    end

    if (use_flush) begin
      if (ecnt != 3'd0) begin
        seq_next     = replay_cls;
        seq_len_next = ecnt;
        seq_vis_next = 1'b1;
        ecnt_next    = 3'd0;
      end else begin
        emit      = 1'b1;
        emit_byte = '0;
        emit_eot  = 1'b1;
        emit_len  = count_ext[15:0];
        if (out_free) begin
          in_markup_next  = 1'b0;
          mcnt_next       = '0;
          ecnt_next       = '0;
          space_pend_next = 1'b0;
          emitted_next    = '0;
          lim_hit_next    = 1'b0;
          last_pend_next  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    mhead <= mhead_next;
    ebuf  <= ebuf_next;
    seq   <= seq_next;
    if (emit && out_free) begin
      m_tdata <= {emit_len, emit_byte};
      m_tlast <= emit_eot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit      <= hvt_pkg::LIMIT_RESET;
      in_markup  <= 1'b0;
      mcnt       <= '0;
      ecnt       <= '0;
      space_pend <= 1'b0;
      emitted    <= '0;
      lim_hit    <= 1'b0;
      seq_len    <= '0;
      seq_vis    <= 1'b0;
      last_pend  <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        limit <= cfg_data;
      end
      in_markup  <= in_markup_next;
      mcnt       <= mcnt_next;
      ecnt       <= ecnt_next;
      space_pend <= space_pend_next;
      emitted    <= emitted_next;
      lim_hit    <= lim_hit_next;
      seq_len    <= seq_len_next;
      seq_vis    <= seq_vis_next;
      last_pend  <= last_pend_next;
      if (emit && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/html_visible_text_filter.sv =====
// ----------------------------------------------------------------------------
// html_visible_text_filter
// Strips markup from an HTML byte stream and emits the visible text.
// ----------------------------------------------------------------------------
// Bytes enter on the s_ stream into a four-beat queue and leave as text beats
// on the m_ stream through an output register. Plain text flows at one byte
// per cycle while the receiver takes every beat. A byte that releases a held
// space gives two output beats, the space first. An entity that breaks off
// first loads the replay, then replays '&', up to four held bytes and the
// breaking byte in turn. The last byte of a range is followed by the end
// marker, after the replay of an entity still open. The output side sends
// one beat per cycle at most; the back end executes one step per cycle while
// no output beat waits for the receiver. The end marker beat has tlast set,
// text byte 0 and the text length.
module html_visible_text_filter #(
  parameter int COUNT_BITS = hvt_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] in_byte
  input  logic        s_tlast,    // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // [7:0] text_byte, [23:8] text_length
  output logic        m_tlast,    // end_of_text
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // output_limit
);

  logic               push;
  hvt_pkg::hvt_item_t push_item;
  logic               q_full;
  logic               q_pop;
  logic               q_valid;
  hvt_pkg::hvt_item_t q_head;

  hvt_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  hvt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  hvt_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

// ===== design/hvt_checker.sv =====
// ----------------------------------------------------------------------------
// hvt_checker
// Port-level checks of the visible-text filter, bound to the top level.
// ----------------------------------------------------------------------------
module hvt_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tlast
);

  // nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output beat right after reset");

  // end marker carries a zero text byte
  a_marker_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[7:0] == 8'h00)
    else $error("end marker with nonzero text byte");

  // text beats carry no length
  a_text_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[23:8] == 16'h0000)
    else $error("text beat with nonzero length field");

  // whitespace controls are collapsed, only a plain space may appear
  a_no_ctrl_ws: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !(m_tdata[7:0] >= 8'h09 && m_tdata[7:0] <= 8'h0D))
    else $error("raw whitespace control in text");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output beat changed");

endmodule

bind html_visible_text_filter hvt_checker u_hvt_checker (.*);

// ===== bench/html_visible_text_filter_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// html_visible_text_filter_test
// Streams HTML bytes into the visible-text filter and checks every text beat and
// end marker against a behavioral model kept in the bench, or against a typed
// row's own expectation. A short table of hand-made rows comes first, then random
// documents of words, whitespace, tags and entities, under several output limits.
// ----------------------------------------------------------------------------
module html_visible_text_filter_test;

  localparam int RANDOM_ITEMS   = 200;
  localparam int CALM_ITEMS     = 40;
  localparam int SETTLE_CYCLES  = 32;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_BEATS      = 8;
  localparam int NUM_ENTITIES   = 6;
  localparam int DIRECTED_ROWS  = 28;
  localparam logic [15:0] LIMIT_AFTER_RESET = 16'd640;

  typedef enum logic {ROW_BYTE, ROW_LIMIT} row_kind_e;
  typedef enum int {ENT_NONE, ENT_PREFIX, ENT_WHOLE} entity_match_e;

  typedef struct packed {
    logic [7:0]  text_byte;
    logic        eot;
    logic [15:0] length;
  } text_beat_t;

  // typed rows carry their own expectation: an optional text byte, then the
  // end marker when the row is the last byte of its range
  typedef struct packed {
    row_kind_e   kind;
    logic [15:0] value;
    logic        last;
    logic        typed;
    logic        text_en;
    logic [7:0]  text;
    logic [15:0] length;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;    // [7:0] in_byte
  logic        s_tlast;    // last_byte
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;    // [7:0] text_byte, [23:8] text_length
  logic        m_tlast;    // end_of_text
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;   // output_limit

  html_visible_text_filter u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_BYTE,  16'h00, 1'b0, 1'b1, 1'b1, 8'h00, 16'd0},
    '{ROW_BYTE,  16'hFF, 1'b1, 1'b1, 1'b1, 8'hFF, 16'd2},
    '{ROW_BYTE,  " ",    1'b0, 1'b1, 1'b0, 8'h00, 16'd0},  // no leading space
    '{ROW_BYTE,  "<",    1'b0, 1'b1, 1'b0, 8'h00, 16'd0},
    '{ROW_BYTE,  "B",    1'b0, 1'b1, 1'b0, 8'h00, 16'd0},
    '{ROW_BYTE,  "R",    1'b0, 1'b1, 1'b0, 8'h00, 16'd0},
    '{ROW_BYTE,  ">",    1'b0, 1'b1, 1'b0, 8'h00, 16'd0},  // break before any text
    '{ROW_BYTE,  "H",    1'b0, 1'b1, 1'b1, "H",   16'd0},
    '{ROW_BYTE,  "<",    1'b0, 1'b1, 1'b0, 8'h00, 16'd0},
    '{ROW_BYTE,  "/",    1'b0, 1'b1, 1'b0, 8'h00, 16'd0},
    '{ROW_BYTE,  "D",    1'b0, 1'b1, 1'b0, 8'h00, 16'd0},
    '{ROW_BYTE,  "i",    1'b0, 1'b1, 1'b0, 8'h00, 16'd0},
    '{ROW_BYTE,  "V",    1'b0, 1'b1, 1'b0, 8'h00, 16'd0},
    '{ROW_BYTE,  ">",    1'b0, 1'b1, 1'b0, 8'h00, 16'd0},  // space held back
    '{ROW_BYTE,  "&",    1'b0, 1'b1, 1'b0, 8'h00, 16'd0},
    '{ROW_BYTE,  "x",    1'b0, 1'b0, 1'b0, 8'h00, 16'd0},  // broken entity
    '{ROW_BYTE,  16'h09, 1'b0, 1'b1, 1'b0, 8'h00, 16'd0},
    '{ROW_BYTE,  "&",    1'b0, 1'b1, 1'b0, 8'h00, 16'd0},
    '{ROW_BYTE,  "l",    1'b0, 1'b1, 1'b0, 8'h00, 16'd0},
    '{ROW_BYTE,  "t",    1'b0, 1'b1, 1'b0, 8'h00, 16'd0},
    '{ROW_BYTE,  ";",    1'b0, 1'b0, 1'b0, 8'h00, 16'd0},
    '{ROW_BYTE,  "&",    1'b0, 1'b1, 1'b0, 8'h00, 16'd0},
    '{ROW_BYTE,  "a",    1'b0, 1'b1, 1'b0, 8'h00, 16'd0},
    '{ROW_BYTE,  "p",    1'b1, 1'b0, 1'b0, 8'h00, 16'd0},  // entity open at the end
    '{ROW_LIMIT, 16'd1,  1'b0, 1'b0, 1'b0, 8'h00, 16'd0},
    '{ROW_BYTE,  "Z",    1'b1, 1'b1, 1'b0, 8'h00, 16'd0},  // no room for any text
    '{ROW_LIMIT, 16'hFFFF, 1'b0, 1'b0, 1'b0, 8'h00, 16'd0},
    '{ROW_BYTE,  "<",    1'b1, 1'b1, 1'b0, 8'h00, 16'd0}   // open markup dropped
  };

  text_beat_t  expected_text [$];
  text_beat_t  step_beats [$];
  logic [7:0]  html_bytes [$];
  int          errors = 0;
  bit          calm = 1'b0;
  int          idle_cycles = 0;

  // filter model state
  logic [15:0] limit_reg;
  bit          in_tag;
  logic [31:0] tag_head;
  int          head_len;
  logic [47:0] amp_buf;
  int          amp_len;
  bit          space_held;
  logic [15:0] text_count;
  bit          limit_hit;

  function automatic string entity_name(input int e);
    case (e)
      0: return "amp;";
      1: return "lt;";
      2: return "gt;";
      3: return "quot;";
      4: return "#39;";
      default: return "apos;";
    endcase
  endfunction

  function automatic void clear_stream();
    in_tag     = 1'b0;
    tag_head   = '0;
    head_len   = 0;
    amp_buf    = '0;
    amp_len    = 0;
    space_held = 1'b0;
    text_count = '0;
    limit_hit  = 1'b0;
  endfunction

  function automatic void note_beat(input logic [7:0] b, input logic eot,
                                    input logic [15:0] len);
    text_beat_t beat;
    beat.text_byte = b;
    beat.eot       = eot;
    beat.length    = len;
    if (step_beats.size() < MAX_BEATS) step_beats.push_back(beat);
  endfunction

  function automatic void count_up();
    if (text_count != 16'hFFFF) text_count = text_count + 16'd1;
  endfunction

  // a pending space takes a slot as well
  function automatic bit at_limit();
    if (limit_hit) return 1'b1;
    if (int'(text_count) + int'(space_held) + 1 >= int'(limit_reg)) begin
      limit_hit = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void emit_text(input logic [7:0] b);
    if (at_limit()) return;
    if (space_held) begin
      note_beat(" ", 1'b0, 16'd0);
      count_up();
      space_held = 1'b0;
    end
    note_beat(b, 1'b0, 16'd0);
    count_up();
  endfunction

  function automatic void note_space();
    if (text_count != 0) space_held = 1'b1;
  endfunction

  function automatic bit head_matches(input string pat);
    logic [7:0] low;
    int i;
    if (head_len < pat.len()) return 1'b0;
    for (i = 0; i < pat.len(); i++) begin
      low = tag_head[8*i +: 8];
      if (low >= "A" && low <= "Z") low = low + 8'h20;
      if (low != pat[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void plain_byte(input logic [7:0] b);
    if (at_limit()) return;
    if (b == "<") begin
      in_tag   = 1'b1;
      tag_head = '0;
      head_len = 0;
    end else if (in_tag) begin
      if (b == ">") begin
        if (head_matches("br") || head_matches("/p") || head_matches("/div") ||
            head_matches("/li"))
          note_space();
        in_tag   = 1'b0;
        tag_head = '0;
        head_len = 0;
      end else if (head_len < 4) begin
        tag_head[8*head_len +: 8] = b;
        head_len++;
      end
    end else if (b == "&") begin
      amp_buf = "&";
      amp_len = 1;
    end else if (b == " " || (b >= 8'h09 && b <= 8'h0D)) begin
      note_space();
    end else begin
      emit_text(b);
    end
  endfunction

  function automatic void replay(input int held);
    int i;
    emit_text("&");
    for (i = 1; i < held && i < 6; i++) plain_byte(amp_buf[8*i +: 8]);
  endfunction

  function automatic void filter_byte(input logic [7:0] b);
    logic [47:0]   tail;
    logic [7:0]    val;
    entity_match_e found;
    string         name;
    bit            ok;
    int            held, k, e, i;
    if (amp_len == 0) begin
      plain_byte(b);
      return;
    end
    held = (amp_len > 5) ? 5 : amp_len;
    tail = '0;
    k = 0;
    for (i = 1; i < held; i++) begin
      tail[8*k +: 8] = amp_buf[8*i +: 8];
      k++;
    end
    tail[8*k +: 8] = b;
    k++;
    // first entity whose name starts with the held bytes decides
    found = ENT_NONE;
    val   = 8'h00;
    for (e = 0; e < NUM_ENTITIES; e++) begin
      name = entity_name(e);
      if (found == ENT_NONE && k <= name.len()) begin
        ok = 1'b1;
        for (i = 0; i < k; i++) if (tail[8*i +: 8] != name[i]) ok = 1'b0;
        if (ok) begin
          found = (k == name.len()) ? ENT_WHOLE : ENT_PREFIX;
          case (e)
            0: val = "&";
            1: val = "<";
            2: val = ">";
            3: val = "\"";
            default: val = "'";
          endcase
        end
      end
    end
    if (found == ENT_WHOLE) begin
      amp_len = 0;
      amp_buf = '0;
      emit_text(val);
    end else if (found == ENT_PREFIX && held < 5) begin
      amp_buf[8*held +: 8] = b;
      amp_len = held + 1;
    end else begin
      amp_len = 0;
      replay(held);
      amp_buf = '0;
      plain_byte(b);
    end
  endfunction

  function automatic void predict_text(input logic [7:0] b, input logic last);
    int held;
    step_beats.delete();
    filter_byte(b);
    if (last) begin
      if (amp_len > 0) begin
        held = (amp_len > 5) ? 5 : amp_len;
        amp_len = 0;
        replay(held);
        amp_buf = '0;
      end
      note_beat(8'h00, 1'b1, text_count);
      clear_stream();
    end
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic last, input logic typed,
                           input logic text_en, input logic [7:0] text,
                           input logic [15:0] length);
    int i;
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    s_tlast  = last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_text(b, last);
    if (typed) begin
      step_beats.delete();
      if (text_en) note_beat(text, 1'b0, 16'd0);
      if (last) note_beat(8'h00, 1'b1, length);
    end
    for (i = 0; i < step_beats.size(); i++) expected_text.push_back(step_beats[i]);
    @(negedge clk);
  endtask

  // only written once the block has gone quiet
  task automatic write_limit(input logic [15:0] value);
    s_tvalid = 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    limit_reg = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic add_token();
    int         pick, n, i;
    string      name;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) begin
        c = 8'($urandom_range(33, 126));
        if (c == "<" || c == "&") c = "e";
        html_bytes.push_back(c);
      end
    end else if (pick < 48) begin
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) begin
        c = 8'($urandom_range(8, 13));
        html_bytes.push_back((c == 8'h08) ? 8'h20 : c);
      end
    end else if (pick < 72) begin
      html_bytes.push_back("<");
      // a second '<' restarts the head
      if ($urandom_range(0, 7) == 0) begin
        html_bytes.push_back("i");
        html_bytes.push_back("<");
      end
      case ($urandom_range(0, 12))
        0: name = "br";
        1: name = "BR";
        2: name = "bR /";
        3: name = "/p";
        4: name = "/P";
        5: name = "/div";
        6: name = "/DiV";
        7: name = "/li";
        8: name = "/LI";
        9: name = "p class=x";
        10: name = "span";
        11: name = "/d";
        default: name = "/divx";
      endcase
      for (i = 0; i < name.len(); i++) html_bytes.push_back(name[i]);
      if ($urandom_range(0, 9) != 0) html_bytes.push_back(">");
    end else if (pick < 84) begin
      name = entity_name($urandom_range(0, NUM_ENTITIES - 1));
      html_bytes.push_back("&");
      for (i = 0; i < name.len(); i++) html_bytes.push_back(name[i]);
    end else if (pick < 94) begin
      name = entity_name($urandom_range(0, NUM_ENTITIES - 1));
      n = $urandom_range(0, name.len() - 1);
      html_bytes.push_back("&");
      for (i = 0; i < n; i++) html_bytes.push_back(name[i]);
      case ($urandom_range(0, 4))
        0: html_bytes.push_back(8'($urandom_range("a", "z")));
        1: html_bytes.push_back("<");
        2: html_bytes.push_back("&");
        3: html_bytes.push_back(" ");
        default: html_bytes.push_back(8'($urandom_range(0, 255)));
      endcase
    end else begin
      html_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver side: random stall bursts until the quiet tail of the run
  initial begin
    int stall;
    stall    = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        m_tready = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall    = $urandom_range(1, 8) - 1;
        m_tready = 1'b0;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    text_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got byte %h end %b length %0d",
                 $time, m_tdata[7:0], m_tlast, m_tdata[23:8]);
        errors++;
      end else begin
        want = expected_text.pop_front();
        if (m_tdata[7:0] !== want.text_byte || m_tlast !== want.eot ||
            m_tdata[23:8] !== want.length) begin
          $display("%0t: expected byte %h end %b length %0d, got byte %h end %b length %0d",
                   $time, want.text_byte, want.eot, want.length,
                   m_tdata[7:0], m_tlast, m_tdata[23:8]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    stim_row_t   row;
    logic [15:0] new_limit;
    int          r, i, sent, span;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    limit_reg = LIMIT_AFTER_RESET;
    clear_stream();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (r = 0; r < DIRECTED_ROWS; r++) begin
      row = directed_rows[r];
      if (row.kind == ROW_LIMIT) write_limit(row.value);
      else push_byte(row.value[7:0], row.last, row.typed, row.text_en, row.text, row.length);
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 6))
          0: new_limit = 16'($urandom_range(1, 3));
          1, 2: new_limit = 16'($urandom_range(4, 40));
          3: new_limit = LIMIT_AFTER_RESET;
          4: new_limit = 16'hFFFF;
          default: new_limit = 16'($urandom_range(1, 16'hFFFF));
        endcase
        write_limit(new_limit);
      end
      html_bytes.delete();
      span = $urandom_range(1, 32);
      while (html_bytes.size() < span) add_token();
      for (i = 0; i < html_bytes.size(); i++)
        push_byte(html_bytes[i], i == html_bytes.size() - 1, 1'b0, 1'b0, 8'h00, 16'd0);
      sent += html_bytes.size();
      if (sent >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
    end

    s_tvalid = 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
